// File: rtl/pwpr_pkg.sv
// Shared types and constants for the OOK pulse-width packet receiver.
// No dependencies.
package pwpr_pkg;

    // Event codes on the mode field
    localparam logic [1:0] MODE_PULSE   = 2'd0;
    localparam logic [1:0] MODE_TIMEOUT = 2'd1;
    localparam logic [1:0] MODE_REARM   = 2'd2;

    // Configuration register indexes
    localparam logic REG_PREAMBLE = 1'b0;
    localparam logic REG_ONE      = 1'b1;

    localparam logic [15:0] PREAMBLE_RESET = 16'd1000;
    localparam logic [15:0] ONE_RESET      = 16'd100;

    // Decoded packet covers the first five bytes
    localparam int unsigned DECODE_BITS = 40;

    localparam logic [7:0] HDR_BYTE0 = 8'h3e;
    localparam logic [7:0] HDR_BYTE1 = 8'h35;
    localparam logic [7:0] HDR_BYTE2 = 8'h6e;
    localparam logic [3:0] HDR_NIBBLE = 4'ha;

    localparam logic [7:0] CMD_UP   = 8'h11;
    localparam logic [7:0] CMD_STOP = 8'h55;
    localparam logic [7:0] CMD_DOWN = 8'h33;

    // Action codes reported on the result
    localparam logic [1:0] ACT_UP      = 2'd0;
    localparam logic [1:0] ACT_STOP    = 2'd1;
    localparam logic [1:0] ACT_DOWN    = 2'd2;
    localparam logic [1:0] ACT_INVALID = 2'd3;

    typedef struct packed {
        logic       packet_ready;
        logic       header_ok;
        logic [3:0] address;
        logic [1:0] action;
        logic       receiving;
        logic [5:0] bits_received;
    } result_t;

endpackage

// File: rtl/pwpr_core.sv
// Receiver state, threshold registers and per-event decode.
// Depends on pwpr_pkg.
module pwpr_core #(
    parameter int unsigned FRAME_BITS = 40
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [15:0]      cfg_data,
    input  logic             accept,
    input  logic [1:0]       mode,
    input  logic [15:0]      high_time,
    output pwpr_pkg::result_t result
);
    import pwpr_pkg::*;

    localparam int unsigned CW = $clog2(FRAME_BITS + 1);
    localparam int unsigned IW = $clog2(FRAME_BITS);
    localparam logic [CW-1:0] FRAME_CNT = CW'(FRAME_BITS);
    localparam logic [IW-1:0] TOP_IDX   = IW'(FRAME_BITS - 1);

    logic [15:0]           pre_thr_reg;
    logic [15:0]           one_thr_reg;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  in_frame_reg, in_frame_next;
    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic [CW-1:0]         cnt_inc;
    logic [DECODE_BITS-1:0] head;
    logic                  ready;

    assign cnt_inc = cnt_reg + CW'(1);

    always_comb
    begin
        cnt_next      = cnt_reg;
        in_frame_next = in_frame_reg;
        frame_next    = frame_reg;
        if (accept)
        begin
            unique case (mode)
                MODE_PULSE:
                begin
                    if (high_time > pre_thr_reg && cnt_reg < FRAME_CNT)
                    begin
                        in_frame_next = 1'b1;
                        cnt_next      = '0;
                    end
                    else if (in_frame_reg)
                    begin
                        // MSB first; count stays below FRAME_BITS while in frame
                        frame_next[TOP_IDX - cnt_reg[IW-1:0]] = (high_time > one_thr_reg);
                        cnt_next      = cnt_inc;
                        in_frame_next = (cnt_inc < FRAME_CNT);
                    end
                end
                MODE_TIMEOUT:
                begin
                    // held packet survives a timeout
                    if (cnt_reg < FRAME_CNT)
                    begin
                        in_frame_next = 1'b0;
                        cnt_next      = '0;
                    end
                end
                MODE_REARM:
                begin
                    in_frame_next = 1'b0;
                    cnt_next      = '0;
                end
                default:
                begin
                    cnt_next = cnt_reg;
                end
            endcase
        end
    end

    assign ready = (cnt_next >= FRAME_CNT);
    assign head  = frame_next[FRAME_BITS-1 -: DECODE_BITS];

    always_comb
    begin
        result.packet_ready  = ready;
        result.header_ok     = 1'b0;
        result.address       = 4'd0;
        result.action        = ACT_INVALID;
        result.receiving     = in_frame_next;
        result.bits_received = cnt_next[5:0];
        if (ready)
        begin
            result.header_ok = (head[39:32] == HDR_BYTE0) && (head[31:24] == HDR_BYTE1)
                            && (head[23:16] == HDR_BYTE2) && (head[15:12] == HDR_NIBBLE);
            result.address   = head[11:8];
            unique case (head[7:0])
                CMD_UP:   result.action = ACT_UP;
                CMD_STOP: result.action = ACT_STOP;
                CMD_DOWN: result.action = ACT_DOWN;
                default:  result.action = ACT_INVALID;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_thr_reg  <= PREAMBLE_RESET;
            one_thr_reg  <= ONE_RESET;
            cnt_reg      <= '0;
            in_frame_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_PREAMBLE)
                pre_thr_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_ONE)
                one_thr_reg <= cfg_data;
            cnt_reg      <= cnt_next;
            in_frame_reg <= in_frame_next;
        end
    end

    // packet bits need no reset; never read before written in a packet
    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

endmodule

// File: rtl/pwpr_out_buf.sv
// Result register with one skid entry behind it.
// Depends on pwpr_pkg.
module pwpr_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pwpr_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output pwpr_pkg::result_t out_data
);
    import pwpr_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;
    logic    pop;

    assign pop       = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                out_valid_reg <= push;
        end
        else if (push && out_valid_reg)
            skid_valid_reg <= 1'b1;
        else if (push)
            out_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (push)
                out_reg <= push_data;
        end
        else if (push && out_valid_reg)
            skid_reg <= push_data;
        else if (push)
            out_reg <= push_data;
    end

endmodule

// File: rtl/ook_pulse_width_packet_receiver.sv
// A result beat is registered in the output buffer; a result stall can hold it there or in the skid entry.
// One event per cycle while in_stall is low; the state update and packet decode are combinational.
// in_stall rises only when the result register and its skid entry are both full.
// Reset (rst_n low, async) clears the bit count and frame flag, loads default
// thresholds (1000 / 100) and empties the result buffer; packet bits are not cleared.
// Built from pwpr_core and pwpr_out_buf; depends on pwpr_pkg.
module ook_pulse_width_packet_receiver #(
    parameter int unsigned FRAME_BITS = 40   // data bits per packet, 40..63
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: index 0 preamble threshold, 1 bit-one threshold
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    // event channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [15:0] high_time,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        packet_ready,
    output logic        header_ok,
    output logic [3:0]  address,
    output logic [1:0]  action,
    output logic        receiving,
    output logic [5:0]  bits_received
);
    import pwpr_pkg::*;

    logic    accept;
    logic    buf_full;
    result_t core_result;
    result_t buf_result;

    // an event beat is taken whenever the skid entry is free
    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    // state update and decode of the new state
    pwpr_core #(
        .FRAME_BITS (FRAME_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .mode      (mode),
        .high_time (high_time),
        .result    (core_result)
    );

    // result register plus skid, so input keeps flowing under a short stall
    pwpr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (core_result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (buf_result)
    );

    assign packet_ready  = buf_result.packet_ready;
    assign header_ok     = buf_result.header_ok;
    assign address       = buf_result.address;
    assign action        = buf_result.action;
    assign receiving     = buf_result.receiving;
    assign bits_received = buf_result.bits_received;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for ook_pulse_width_packet_receiver: queue-fed event driver,
// result monitor with scoreboard and an in-bench receiver predictor.
// Depends on rtl/pwpr_pkg.sv and rtl/ook_pulse_width_packet_receiver.sv.
module testbench;
    import pwpr_pkg::*;

    localparam int unsigned FRAME_LEN = 40;
    // The mode field has a fourth code the block must treat as a no-op.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int unsigned HOLD_OFF_CYCLES = 60;

    // Threshold settings per phase; phase 0 runs on reset values and is not written.
    localparam int NUM_PHASES = 6;
    localparam int unsigned PHASE_PRE[NUM_PHASES]   = '{1000, 65535, 0, 3000, 20000, 1000};
    localparam int unsigned PHASE_ONE[NUM_PHASES]   = '{100, 0, 65535, 2999, 150, 100};
    localparam int unsigned PHASE_ITEMS[NUM_PHASES] = '{300, 150, 150, 400, 400, 500};

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] width;
    } line_event_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = REG_PREAMBLE;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  mode = MODE_PULSE;
    logic [15:0] high_time = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        packet_ready;
    logic        header_ok;
    logic [3:0]  address;
    logic [1:0]  action;
    logic        receiving;
    logic [5:0]  bits_received;

    ook_pulse_width_packet_receiver #(
        .FRAME_BITS(FRAME_LEN)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .high_time    (high_time),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .packet_ready (packet_ready),
        .header_ok    (header_ok),
        .address      (address),
        .action       (action),
        .receiving    (receiving),
        .bits_received(bits_received)
    );

    always #10 clk = ~clk;

    // Pending events, expected statuses, bookkeeping
    line_event_t pulse_q[$];
    result_t     status_q[$];
    int unsigned queued_cnt = 0;
    int unsigned accepted_cnt = 0;
    int unsigned mismatch_cnt = 0;
    bit          quiet_run = 1'b0;     // no idling on either side
    logic        long_hold = 1'b0;     // receiver hold-off request
    int unsigned send_gap = 0;
    int unsigned stall_run = 0;
    line_event_t next_ev;
    result_t     expected;
    result_t     got;

    // Receiver model state, our own copy of thresholds included
    logic [15:0] pre_thr = PREAMBLE_RESET;
    logic [15:0] one_thr = ONE_RESET;
    int unsigned rx_count = 0;
    bit          rx_in_frame = 1'b0;
    logic [63:0] rx_bits = '0;

    // Advance the receiver model by one event and return the status it reports.
    function automatic result_t advance_receiver(logic [1:0] ev_mode, logic [15:0] width);
        result_t r;
        logic [7:0] b3;
        logic [7:0] b4;
        r = '0;
        r.action = ACT_INVALID;
        case (ev_mode)
            MODE_PULSE:
            begin
                // a preamble only opens a packet when nothing complete is held
                if (width > pre_thr && rx_count < FRAME_LEN)
                begin
                    rx_in_frame = 1'b1;
                    rx_count = 0;
                end
                else if (rx_in_frame)
                begin
                    if (rx_count < 64)
                        rx_bits[63 - rx_count] = (width > one_thr);
                    rx_count++;
                    if (rx_count >= FRAME_LEN)
                        rx_in_frame = 1'b0;
                end
            end
            MODE_TIMEOUT:
            begin
                // a held packet survives a timeout
                if (rx_count < FRAME_LEN)
                begin
                    rx_in_frame = 1'b0;
                    rx_count = 0;
                end
            end
            MODE_REARM:
            begin
                rx_count = 0;
                rx_in_frame = 1'b0;
            end
            default: ;
        endcase
        if (rx_count >= FRAME_LEN)
        begin
            b3 = rx_bits[39:32];
            b4 = rx_bits[31:24];
            r.packet_ready = 1'b1;
            r.header_ok = (rx_bits[63:56] == HDR_BYTE0) && (rx_bits[55:48] == HDR_BYTE1) &&
                          (rx_bits[47:40] == HDR_BYTE2) && (b3[7:4] == HDR_NIBBLE);
            r.address = b3[3:0];
            if (b4 == CMD_UP)
                r.action = ACT_UP;
            else if (b4 == CMD_STOP)
                r.action = ACT_STOP;
            else if (b4 == CMD_DOWN)
                r.action = ACT_DOWN;
        end
        r.receiving = rx_in_frame;
        r.bits_received = rx_count[5:0];
        return r;
    endfunction

    task automatic queue_event(logic [1:0] ev_mode, logic [15:0] width);
        line_event_t ev;
        ev.mode = ev_mode;
        ev.width = width;
        pulse_q.push_back(ev);
        queued_cnt++;
    endtask

    // Widths picked against the current thresholds so that packets really form.
    function automatic logic [15:0] preamble_width();
        if (pre_thr == 16'hffff)
            return 16'hffff;
        return 16'($urandom_range(int'(pre_thr) + 1, 65535));
    endfunction

    function automatic logic [15:0] bit_width(bit one);
        int unsigned top;
        top = (one_thr < pre_thr) ? one_thr : pre_thr;
        if (one && one_thr < pre_thr)
            return 16'($urandom_range(int'(one_thr) + 1, int'(pre_thr)));
        return 16'($urandom_range(0, top));
    endfunction

    // Widths that sit on and around the thresholds, plus the extremes.
    function automatic logic [15:0] edgy_width();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return pre_thr + 16'($urandom_range(0, 2)) - 16'd1;
            3: return one_thr + 16'($urandom_range(0, 2)) - 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // One packet: preamble, 40 data bits MSB first, a tail while held, then usually a re-arm.
    // A broken one is cut short by a timeout, a re-arm or a fresh preamble.
    task automatic queue_packet(bit broken);
        logic [39:0] frame;
        int unsigned cut;
        int unsigned k;
        int unsigned tail;
        bit restarted;
        frame[39:32] = 8'($urandom_range(0, 255));
        frame[31:0] = $urandom;
        if ($urandom_range(0, 9) < 9)
        begin
            frame[39:12] = {HDR_BYTE0, HDR_BYTE1, HDR_BYTE2, HDR_NIBBLE};
            if ($urandom_range(0, 3) == 0)
                frame[12 + $urandom_range(0, 27)] ^= 1'b1;   // near-miss header
        end
        case ($urandom_range(0, 4))
            0: frame[7:0] = CMD_UP;
            1: frame[7:0] = CMD_STOP;
            2: frame[7:0] = CMD_DOWN;
            3: frame[7:0] = CMD_STOP ^ (8'd1 << $urandom_range(0, 7));
            default: ;
        endcase
        queue_event(MODE_PULSE, preamble_width());
        cut = broken ? $urandom_range(0, FRAME_LEN - 1) : FRAME_LEN;
        restarted = 1'b0;
        for (k = 0; k < FRAME_LEN; k++)
        begin
            if (k == cut && !restarted)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        queue_event(MODE_TIMEOUT, 16'($urandom));
                        return;
                    end
                    1:
                    begin
                        queue_event(MODE_REARM, 16'($urandom));
                        return;
                    end
                    default:
                    begin
                        // restart inside the packet, then deliver it whole
                        queue_event(MODE_PULSE, preamble_width());
                        restarted = 1'b1;
                        k = 0;
                    end
                endcase
            end
            if ($urandom_range(0, 49) == 0)
                queue_event(MODE_UNUSED, 16'($urandom));
            queue_event(MODE_PULSE, bit_width(frame[39 - k]));
        end
        // held: pulses, preambles and timeouts must all leave the packet alone
        tail = $urandom_range(1, 4);
        repeat (tail)
        begin
            case ($urandom_range(0, 3))
                0: queue_event(MODE_PULSE, preamble_width());
                1: queue_event(MODE_PULSE, edgy_width());
                2: queue_event(MODE_TIMEOUT, 16'($urandom));
                default: queue_event(MODE_UNUSED, 16'($urandom));
            endcase
        end
        if ($urandom_range(0, 9) != 0)
            queue_event(MODE_REARM, 16'($urandom));
    endtask

    // Mostly packets with random content, some broken ones and loose noise.
    task automatic queue_random_traffic(int unsigned n);
        int unsigned base;
        int unsigned pick;
        base = queued_cnt;
        while (queued_cnt - base < n)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                queue_packet(1'b0);
            else if (pick < 8)
                queue_packet(1'b1);
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: queue_event(MODE_PULSE, edgy_width());
                        6, 7: queue_event(MODE_TIMEOUT, 16'($urandom));
                        8: queue_event(MODE_REARM, 16'($urandom));
                        default: queue_event(MODE_UNUSED, 16'($urandom));
                    endcase
                end
            end
        end
    endtask

    // Wait until every queued event is accepted and its status has come back.
    task automatic drain();
        while (accepted_cnt != queued_cnt || status_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);   // a little margin after the last result
    endtask

    task automatic note_mismatch(string what);
        string exp_s;
        string got_s;
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
        begin
            exp_s = $sformatf("rdy=%0d hdr=%0d addr=%0h act=%0d rx=%0d bits=%0d",
                              expected.packet_ready, expected.header_ok, expected.address,
                              expected.action, expected.receiving, expected.bits_received);
            got_s = $sformatf("rdy=%0d hdr=%0d addr=%0h act=%0d rx=%0d bits=%0d",
                              got.packet_ready, got.header_ok, got.address,
                              got.action, got.receiving, got.bits_received);
            $display("%0t: %s: expected %s, got %s", $realtime, what, exp_s, got_s);
        end
    endtask

    // Event driver: an accepted beat is predicted on the spot; a new beat is
    // only presented once the current one has gone, with random gaps between.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            mode <= MODE_PULSE;
            high_time <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                status_q.push_back(advance_receiver(mode, high_time));
                accepted_cnt++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pulse_q.size() > 0)
                begin
                    next_ev = pulse_q.pop_front();
                    in_valid <= 1'b1;
                    mode <= next_ev.mode;
                    high_time <= next_ev.width;
                    // sometimes, outside a quiet run, idle for a random gap after this beat goes
                    if (!quiet_run && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 11);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: check against the oldest expectation, then decide the stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{packet_ready, header_ok, address, action, receiving, bits_received};
                if (status_q.size() == 0)
                begin
                    expected = '0;
                    note_mismatch("result beat with nothing expected");
                end
                else
                begin
                    expected = status_q.pop_front();
                    if (got !== expected)
                        note_mismatch("status mismatch");
                end
            end
            if (stall_run > 0)
            begin
                stall_run--;
                out_stall <= 1'b1;
            end
            else if (long_hold)
                out_stall <= 1'b1;
            else if (!quiet_run && $urandom_range(0, 9) == 0)
            begin
                stall_run = $urandom_range(0, 10);   // start a random stall burst
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Long receiver hold-off while plenty of events are still waiting, so the
    // result buffer fills and the block has to stall its event input.
    initial
    begin
        while (!(accepted_cnt >= 100 && pulse_q.size() > 50))
            @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #8_000_000;
        $display("testbench: errors");
        $finish;
    end

    // Stimulus sequencer
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats on reset thresholds (preamble 1000, one 100).
        queue_event(MODE_UNUSED, 16'hffff);    // unused code: status only
        queue_event(MODE_PULSE, 16'h0000);     // idle pulse, ignored
        queue_event(MODE_PULSE, 16'd1000);     // at the threshold: not a preamble
        queue_event(MODE_TIMEOUT, 16'hffff);
        queue_event(MODE_REARM, 16'h0000);
        queue_event(MODE_PULSE, 16'd1001);     // just over: packet opens
        queue_event(MODE_PULSE, 16'd101);      // one
        queue_event(MODE_PULSE, 16'd100);      // zero, on the bit threshold
        queue_event(MODE_UNUSED, 16'h0000);    // no effect mid-packet
        queue_event(MODE_PULSE, 16'd1000);     // widest data bit
        queue_event(MODE_PULSE, 16'hffff);     // preamble inside packet restarts it
        queue_event(MODE_PULSE, 16'h0000);
        queue_event(MODE_TIMEOUT, 16'h0000);   // aborts the partial packet
        queue_event(MODE_PULSE, 16'hffff);
        queue_event(MODE_REARM, 16'hffff);     // aborts too
        queue_random_traffic(PHASE_ITEMS[0]);
        drain();

        for (int p = 1; p < NUM_PHASES; p++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= REG_PREAMBLE;
            cfg_data <= 16'(PHASE_PRE[p]);
            @(posedge clk);
            cfg_index <= REG_ONE;
            cfg_data <= 16'(PHASE_ONE[p]);
            @(posedge clk);
            cfg_we <= 1'b0;
            pre_thr = 16'(PHASE_PRE[p]);
            one_thr = 16'(PHASE_ONE[p]);
            // last phase runs flat out on both sides
            if (p == NUM_PHASES - 1)
                quiet_run = 1'b1;
            queue_random_traffic(PHASE_ITEMS[p]);
            drain();
        end

        if (mismatch_cnt == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
